@@ hw/rtl/att_pkg.sv @@
// shared types and constants for the alarm tick timekeeper
// used by att_cfg_regs, att_tick_core and alarm_tick_timekeeper; no dependencies
package att_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgWdLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWdEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEvLimit  = 2'd2;

  localparam logic [15:0] WdLimitReset = 16'd1200;
  localparam logic [31:0] EvLimitReset = 32'd86400;

  localparam logic [15:0] TickMs         = 16'd10;
  localparam logic [6:0]  TicksPerSecond = 7'd100;
  localparam logic [5:0]  SecsPerMinute  = 6'd60;
  localparam logic [15:0] ButtonAgeMax   = 16'hFFFF;

  typedef struct packed {
    logic [15:0] wd_limit;
    logic        wd_enable;
    logic [31:0] ev_limit;
  } cfg_t;

  typedef struct packed {
    logic        beep_request;
    logic [15:0] beep_length_ms;
    logic        kick_watchdog;
    logic        event_pending;
    logic        sensor_present;
    logic [4:0]  clear_mask;
  } item_t;

  typedef struct packed {
    logic signed [15:0] millis;
    logic signed [15:0] seconds;
    logic signed [15:0] minutes;
    logic [31:0]        uptime_s;
    logic [15:0]        button_age_s;
    logic [31:0]        event_age_s;
    logic [31:0]        report_age_s;
    logic [31:0]        front_motion_age_s;
    logic [31:0]        side_motion_age_s;
    logic [31:0]        sensor_absent_s;
    logic               buzzer_enable;
    logic               reset_request;
  } res_t;

  // clear mask bit positions
  localparam int unsigned ClrEvent  = 0;
  localparam int unsigned ClrReport = 1;
  localparam int unsigned ClrFront  = 2;
  localparam int unsigned ClrSide   = 3;
  localparam int unsigned ClrButton = 4;

endpackage

@@ hw/rtl/att_cfg_regs.sv @@
// configuration registers of the timekeeper
// depends on att_pkg
module att_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [att_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [att_pkg::CfgDataW-1:0] wr_data,
  output att_pkg::cfg_t                cfg
);
  import att_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wd_limit  <= WdLimitReset;
      cfg_r.wd_enable <= 1'b1;
      cfg_r.ev_limit  <= EvLimitReset;
    end else if (wr_en) begin
      case (wr_index)
        CfgWdLimit:  cfg_r.wd_limit  <= wr_data[15:0];
        CfgWdEnable: cfg_r.wd_enable <= wr_data[0];
        CfgEvLimit:  cfg_r.ev_limit  <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/att_tick_core.sv @@
// timekeeping state and its per-tick update
// depends on att_pkg
module att_tick_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  att_pkg::item_t item,
  input  att_pkg::cfg_t  cfg,
  output att_pkg::res_t  res
);
  import att_pkg::*;

  logic [6:0]  tick_r, tick_nxt, tick_inc;
  logic [5:0]  sec_min_r, sec_min_nxt, sec_min_inc;
  logic [15:0] millis_r, millis_nxt;
  logic [15:0] seconds_r, seconds_nxt;
  logic [15:0] minutes_r, minutes_nxt;
  logic [31:0] uptime_r, uptime_nxt;
  logic [15:0] button_r, button_nxt, button_clr;
  logic [31:0] event_r, event_nxt, event_clr;
  logic [31:0] report_r, report_nxt, report_clr;
  logic [31:0] front_r, front_nxt, front_clr;
  logic [31:0] side_r, side_nxt, side_clr;
  logic [31:0] absent_r, absent_nxt;
  logic [15:0] wd_r, wd_nxt, wd_kick;
  logic        beep_r, beep_nxt, beep_ld;
  logic [15:0] remain_r, remain_nxt, remain_ld;
  logic        boundary, reset_req;

  always_comb begin
    // pending requests first
    beep_ld    = item.beep_request ? 1'b1 : beep_r;
    remain_ld  = item.beep_request ? item.beep_length_ms : remain_r;
    wd_kick    = item.kick_watchdog ? 16'd0 : wd_r;
    event_clr  = item.clear_mask[ClrEvent]  ? 32'd0 : event_r;
    report_clr = item.clear_mask[ClrReport] ? 32'd0 : report_r;
    front_clr  = item.clear_mask[ClrFront]  ? 32'd0 : front_r;
    side_clr   = item.clear_mask[ClrSide]   ? 32'd0 : side_r;
    button_clr = item.clear_mask[ClrButton] ? 16'd0 : button_r;

    // beep countdown
    beep_nxt   = beep_ld;
    remain_nxt = remain_ld;
    if (beep_ld) begin
      if (remain_ld >= TickMs) begin
        remain_nxt = remain_ld - TickMs;
      end else begin
        remain_nxt = 16'd0;
        beep_nxt   = 1'b0;
      end
    end

    millis_nxt = millis_r + TickMs;
    tick_inc   = tick_r + 7'd1;
    boundary   = (tick_inc >= TicksPerSecond);
    tick_nxt   = boundary ? 7'd0 : tick_inc;

    seconds_nxt = seconds_r;
    uptime_nxt  = uptime_r;
    button_nxt  = button_clr;
    wd_nxt      = wd_kick;
    sec_min_inc = sec_min_r + 6'd1;
    sec_min_nxt = sec_min_r;
    minutes_nxt = minutes_r;
    event_nxt   = event_clr;
    report_nxt  = report_clr;
    front_nxt   = front_clr;
    side_nxt    = side_clr;
    absent_nxt  = absent_r;
    reset_req   = 1'b0;

    if (boundary) begin
      seconds_nxt = seconds_r + 16'd1;
      uptime_nxt  = uptime_r + 32'd1;
      if (button_clr < ButtonAgeMax) begin
        button_nxt = button_clr + 16'd1;
      end
      wd_nxt = wd_kick + 16'd1;
      if (sec_min_inc >= SecsPerMinute) begin
        sec_min_nxt = 6'd0;
        minutes_nxt = minutes_r + 16'd1;
      end else begin
        sec_min_nxt = sec_min_inc;
      end
      reset_req = cfg.wd_enable && (wd_nxt > cfg.wd_limit);
      if (item.event_pending && (event_clr < cfg.ev_limit)) begin
        event_nxt = event_clr + 32'd1;
      end
      report_nxt = report_clr + 32'd1;
      front_nxt  = front_clr + 32'd1;
      side_nxt   = side_clr + 32'd1;
      absent_nxt = item.sensor_present ? 32'd0 : absent_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      sec_min_r <= '0;
      millis_r  <= '0;
      seconds_r <= '0;
      minutes_r <= '0;
      uptime_r  <= '0;
      button_r  <= ButtonAgeMax;
      event_r   <= '0;
      report_r  <= '0;
      front_r   <= '0;
      side_r    <= '0;
      absent_r  <= '0;
      wd_r      <= '0;
      beep_r    <= 1'b0;
      remain_r  <= '0;
    end else if (advance) begin
      tick_r    <= tick_nxt;
      sec_min_r <= sec_min_nxt;
      millis_r  <= millis_nxt;
      seconds_r <= seconds_nxt;
      minutes_r <= minutes_nxt;
      uptime_r  <= uptime_nxt;
      button_r  <= button_nxt;
      event_r   <= event_nxt;
      report_r  <= report_nxt;
      front_r   <= front_nxt;
      side_r    <= side_nxt;
      absent_r  <= absent_nxt;
      wd_r      <= wd_nxt;
      beep_r    <= beep_nxt;
      remain_r  <= remain_nxt;
    end
  end

  always_comb begin
    res.millis             = millis_nxt;
    res.seconds            = seconds_nxt;
    res.minutes            = minutes_nxt;
    res.uptime_s           = uptime_nxt;
    res.button_age_s       = button_nxt;
    res.event_age_s        = event_nxt;
    res.report_age_s       = report_nxt;
    res.front_motion_age_s = front_nxt;
    res.side_motion_age_s  = side_nxt;
    res.sensor_absent_s    = absent_nxt;
    res.buzzer_enable      = beep_nxt;
    res.reset_request      = reset_req;
  end

endmodule

@@ hw/rtl/alarm_tick_timekeeper.sv @@
// top level of the 10 ms tick timekeeper: input register, tick core, result register
// depends on att_pkg, att_cfg_regs and att_tick_core
//
// usage
//   in_*   : one transaction per 10 ms tick, carrying the beep request, watchdog
//            kick, event/sensor status and counter clears gathered since the last tick
//   out_*  : one transaction per tick with all counters as they stand after it,
//            plus buzzer enable and the soft watchdog reset request
//   cfg_*  : register writes (watchdog limit, watchdog enable, event age limit),
//            always ready; write only while no tick is in flight
// latency: a tick accepted at edge n is offered on out_* from edge n+1, so it can
//   be taken at edge n+2 at the earliest
// throughput: one tick per cycle; the single-cycle state update between the
//   input register and the result register sets that figure
// reset: rst_n low clears all counters (button age to 65535), the registers
//   to their defaults and both pipeline registers to empty
// stall: while out_ready is low the result register holds and the input
//   register still takes one more tick, after which in_ready drops
module alarm_tick_timekeeper (
  input  logic                         clk,
  input  logic                         rst_n,
  // tick input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_beep_request,
  input  logic [15:0]                  in_beep_length_ms,
  input  logic                         in_kick_watchdog,
  input  logic                         in_event_pending,
  input  logic                         in_sensor_present,
  input  logic [4:0]                   in_clear_mask,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [15:0]           out_millis,
  output logic signed [15:0]           out_seconds,
  output logic signed [15:0]           out_minutes,
  output logic [31:0]                  out_uptime_s,
  output logic [15:0]                  out_button_age_s,
  output logic [31:0]                  out_event_age_s,
  output logic [31:0]                  out_report_age_s,
  output logic [31:0]                  out_front_motion_age_s,
  output logic [31:0]                  out_side_motion_age_s,
  output logic [31:0]                  out_sensor_absent_s,
  output logic                         out_buzzer_enable,
  output logic                         out_reset_request,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [att_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [att_pkg::CfgDataW-1:0] cfg_data
);
  import att_pkg::*;

  cfg_t  cfg;
  item_t item_r, item_in;
  logic  item_valid_r;
  res_t  res, res_r;
  logic  out_valid_r;
  logic  advance;

  // config port never stalls
  assign cfg_ready = 1'b1;

  att_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a tick moves into the core when the result register is free or draining
  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_comb begin
    item_in.beep_request   = in_beep_request;
    item_in.beep_length_ms = in_beep_length_ms;
    item_in.kick_watchdog  = in_kick_watchdog;
    item_in.event_pending  = in_event_pending;
    item_in.sensor_present = in_sensor_present;
    item_in.clear_mask     = in_clear_mask;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_in;
    end
  end

  att_tick_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_millis             = res_r.millis;
  assign out_seconds            = res_r.seconds;
  assign out_minutes            = res_r.minutes;
  assign out_uptime_s           = res_r.uptime_s;
  assign out_button_age_s       = res_r.button_age_s;
  assign out_event_age_s        = res_r.event_age_s;
  assign out_report_age_s       = res_r.report_age_s;
  assign out_front_motion_age_s = res_r.front_motion_age_s;
  assign out_side_motion_age_s  = res_r.side_motion_age_s;
  assign out_sensor_absent_s    = res_r.sensor_absent_s;
  assign out_buzzer_enable      = res_r.buzzer_enable;
  assign out_reset_request      = res_r.reset_request;

  // a held tick is never dropped while the result side stalls
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !advance |=> item_valid_r)
    else $error("pending tick lost from input register");

  // every tick passed to the core shows up as a result
  a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result missing after core update");

  // a taken result with nothing behind it empties the register
  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !advance |=> !out_valid_r)
    else $error("result repeated after transaction");

  // reset request only appears with the watchdog enabled
  a_reset_req_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.reset_request |-> cfg.wd_enable)
    else $error("reset request with watchdog disabled");

endmodule
